>>> design/ssnr_pkg.sv
// Shared types and constants for the segmental SNR meter.
`default_nettype none
package ssnr_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int SEG_LEN_W   = 13;
    localparam int MEAN_W      = 15;
    localparam int COUNT_OUT_W = 17;
    localparam int MANT_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int DBF_W       = 18;
    localparam int RND_SHIFT   = 24;

    localparam logic [SEG_LEN_W-1:0] SEG_LEN_RESET = 13'd160;
    // round(10*log10(2) * 2^16)
    localparam logic [DBF_W-1:0]     DB_FACTOR     = 18'd197283;
    localparam logic [RND_SHIFT-1:0] ROUND_HALF    = 24'h800000;
    localparam logic [MEAN_W-1:0]    SNR_LOW_MAG   = 15'd2560;
    localparam logic [MEAN_W-1:0]    SNR_HIGH      = 15'd12800;
    localparam logic [3:0]           LAST_ROUND    = 4'd15;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic acc;
        logic seg_clear;
        logic log_load_sig;
        logic log_load_noise;
        logic norm;
        logic square;
        logic db_mul;
        logic add;
        logic div_start;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic seg_end;
        logic seg_ok;
        logic last;
        logic norm_done;
        logic sq_done;
        logic div_done;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

>>> design/ssnr_intf.sv
// Channel interfaces: sample pairs, results and the segment length write port.
`default_nettype none
interface ssnr_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [ssnr_pkg::SAMPLE_W-1:0] original_sample;
    logic signed [ssnr_pkg::SAMPLE_W-1:0] degraded_sample;
    logic                                last;

    modport source (output valid, original_sample, degraded_sample, last, input ready);
    modport sink   (input valid, original_sample, degraded_sample, last, output ready);
endinterface

interface ssnr_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ssnr_pkg::MEAN_W-1:0]     mean_snr_db;
    logic        [ssnr_pkg::COUNT_OUT_W-1:0] counted_segments;

    modport source (output valid, mean_snr_db, counted_segments, input ready);
    modport sink   (input valid, mean_snr_db, counted_segments, output ready);
endinterface

interface ssnr_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ssnr_pkg::SEG_LEN_W-1:0]     segment_length;

    modport source (output valid, segment_length, input ready);
    modport sink   (input valid, segment_length, output ready);
endinterface
`default_nettype wire

>>> design/ssnr_ctrl.sv
// Sequencer for the segmental SNR meter: one request at a time through the datapath.
`default_nettype none
module ssnr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ssnr_pkg::status_t status,
    output ssnr_pkg::cmd_t         cmd
);

    typedef enum logic [13:0] {
        S_IDLE       = 14'b00000000000001,
        S_MUL        = 14'b00000000000010,
        S_ACC        = 14'b00000000000100,
        S_CHECK      = 14'b00000000001000,
        S_NORM_SIG   = 14'b00000000010000,
        S_SQ_SIG     = 14'b00000000100000,
        S_LOAD_NOISE = 14'b00000001000000,
        S_NORM_NOISE = 14'b00000010000000,
        S_SQ_NOISE   = 14'b00000100000000,
        S_DB         = 14'b00001000000000,
        S_ADD        = 14'b00010000000000,
        S_DIV_INIT   = 14'b00100000000000,
        S_DIV        = 14'b01000000000000,
        S_OUT        = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.seg_end && status.seg_ok)
                begin
                    cmd.log_load_sig = 1'b1;
                    state_next       = S_NORM_SIG;
                end
                else
                begin
                    cmd.seg_clear = status.seg_end;
                    if (status.last)
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_NORM_SIG:
            begin
                cmd.norm = 1'b1;
                if (status.norm_done)
                begin
                    state_next = S_SQ_SIG;
                end
            end
            S_SQ_SIG:
            begin
                cmd.square = 1'b1;
                if (status.sq_done)
                begin
                    state_next = S_LOAD_NOISE;
                end
            end
            S_LOAD_NOISE:
            begin
                cmd.log_load_noise = 1'b1;
                state_next         = S_NORM_NOISE;
            end
            S_NORM_NOISE:
            begin
                cmd.norm = 1'b1;
                if (status.norm_done)
                begin
                    state_next = S_SQ_NOISE;
                end
            end
            S_SQ_NOISE:
            begin
                cmd.square = 1'b1;
                if (status.sq_done)
                begin
                    state_next = S_DB;
                end
            end
            S_DB:
            begin
                cmd.db_mul = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.add       = 1'b1;
                cmd.seg_clear = 1'b1;
                if (status.last)
                begin
                    state_next = S_DIV_INIT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIV_INIT:
            begin
                // start the divide once the closing segment is in the total
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> design/ssnr_datapath.sv
// Datapath: energy accumulators, shared log2 unit, dB scaling, running total and divider.
`default_nettype none
module ssnr_datapath #(
    parameter int MAX_SEGMENT_LENGTH = 4096,
    parameter int MAX_SEGMENTS       = 65536
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire ssnr_pkg::cmd_t                      cmd,
    output ssnr_pkg::status_t                        status,
    input  wire logic signed [ssnr_pkg::SAMPLE_W-1:0] original_sample,
    input  wire logic signed [ssnr_pkg::SAMPLE_W-1:0] degraded_sample,
    input  wire logic                                last,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ssnr_pkg::SEG_LEN_W-1:0]       cfg_segment_length,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [ssnr_pkg::MEAN_W-1:0]        out_mean,
    output logic [ssnr_pkg::COUNT_OUT_W-1:0]          out_count
);

    localparam int POS_W   = $clog2(MAX_SEGMENT_LENGTH);
    localparam int LEN_W   = POS_W + 1;
    localparam int CMP_W   = (LEN_W > ssnr_pkg::SEG_LEN_W) ? LEN_W : ssnr_pkg::SEG_LEN_W;
    localparam int SIG_W   = POS_W + 31;
    localparam int NOISE_W = POS_W + 33;
    localparam int COUNT_W = $clog2(MAX_SEGMENTS) + 1;
    localparam int TOTAL_W = COUNT_W + 15;
    localparam int E_W     = $clog2(NOISE_W);
    localparam int LOG_W   = E_W + ssnr_pkg::FRAC_W;
    localparam int PROD_W  = LOG_W + ssnr_pkg::DBF_W;
    localparam int RND_W   = PROD_W + 1 - ssnr_pkg::RND_SHIFT;
    localparam int DIVC_W  = $clog2(TOTAL_W);
    localparam int CNTX_W  = COUNT_W + ssnr_pkg::COUNT_OUT_W;
    localparam int MW      = ssnr_pkg::MANT_W;
    localparam int FW      = ssnr_pkg::FRAC_W;
    localparam int OW      = ssnr_pkg::MEAN_W;

    // configuration
    logic [ssnr_pkg::SEG_LEN_W-1:0] seg_len_reg;

    // sample stage
    logic signed [ssnr_pkg::SAMPLE_W-1:0] orig_reg;
    logic signed [ssnr_pkg::SAMPLE_W-1:0] degr_reg;
    logic                                 last_reg;
    logic [30:0]                          sig_sq_reg;
    logic [31:0]                          noise_sq_reg;

    // segment accumulators
    logic [SIG_W-1:0]   sig_sum_reg;
    logic [NOISE_W-1:0] noise_sum_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               seg_end_reg;

    // log2 unit
    logic [NOISE_W-1:0] x_reg;
    logic [E_W-1:0]     e_reg;
    logic [MW-1:0]      m_reg;
    logic [FW-1:0]      frac_reg;
    logic [3:0]         round_reg;
    logic [LOG_W-1:0]   log_sig_reg;

    // dB and totals
    logic [PROD_W-1:0]         db_prod_reg;
    logic                      db_neg_reg;
    logic signed [TOTAL_W-1:0] total_reg;
    logic [COUNT_W-1:0]        count_reg;

    // divider
    logic [TOTAL_W-1:0] q_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [DIVC_W-1:0]  div_cnt_reg;
    logic               mean_neg_reg;

    // output register
    logic              out_valid_reg;
    logic [OW-1:0]     out_mean_reg;
    logic [ssnr_pkg::COUNT_OUT_W-1:0] out_count_reg;

    // combinational
    logic [CMP_W-1:0]   len_eff;
    logic [CMP_W-1:0]   pos_plus;
    logic               seg_end;
    logic signed [31:0] sig_prod;
    logic signed [16:0] diff;
    logic signed [33:0] noise_prod;
    logic [2*MW-1:0]    m_sq;
    logic [MW:0]        m_p;
    logic signed [LOG_W:0] d_log;
    logic [LOG_W-1:0]   d_mag;
    logic [PROD_W:0]    rnd_sum;
    logic [RND_W-1:0]   rnd;
    logic [OW-1:0]      db_val;
    logic [TOTAL_W-1:0] total_mag;
    logic [COUNT_W:0]   rem_sh;
    logic [COUNT_W:0]   rem_diff;
    logic               rem_ge;
    logic [OW-1:0]      q_low;
    logic [CNTX_W-1:0]  cnt_ext;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (seg_len_reg == '0)
        begin
            len_eff = CMP_W'(1);
        end
        else if (CMP_W'(seg_len_reg) > CMP_W'(MAX_SEGMENT_LENGTH))
        begin
            len_eff = CMP_W'(MAX_SEGMENT_LENGTH);
        end
        else
        begin
            len_eff = CMP_W'(seg_len_reg);
        end
    end

    assign pos_plus   = CMP_W'(pos_reg) + CMP_W'(1);
    assign seg_end    = (pos_plus >= len_eff);
    assign sig_prod   = orig_reg * orig_reg;
    assign diff       = $signed({orig_reg[15], orig_reg}) - $signed({degr_reg[15], degr_reg});
    assign noise_prod = diff * diff;
    assign m_sq       = (2 * MW)'(m_reg) * (2 * MW)'(m_reg);
    assign m_p        = m_sq[2*MW-1:MW-1];

    assign d_log = $signed({1'b0, log_sig_reg}) - $signed({1'b0, e_reg, frac_reg});
    assign d_mag = d_log[LOG_W] ? LOG_W'(-d_log) : LOG_W'(d_log);

    assign rnd_sum = {1'b0, db_prod_reg} + (PROD_W + 1)'(ssnr_pkg::ROUND_HALF);
    assign rnd     = rnd_sum[PROD_W:ssnr_pkg::RND_SHIFT];

    always_comb
    begin
        if (db_neg_reg)
        begin
            if (rnd > RND_W'(ssnr_pkg::SNR_LOW_MAG))
            begin
                db_val = ~ssnr_pkg::SNR_LOW_MAG + OW'(1);
            end
            else
            begin
                db_val = ~rnd[OW-1:0] + OW'(1);
            end
        end
        else if (rnd > RND_W'(ssnr_pkg::SNR_HIGH))
        begin
            db_val = ssnr_pkg::SNR_HIGH;
        end
        else
        begin
            db_val = rnd[OW-1:0];
        end
    end

    assign total_mag = total_reg[TOTAL_W-1] ? TOTAL_W'(-total_reg) : TOTAL_W'(total_reg);
    assign rem_sh    = {rem_reg, q_reg[TOTAL_W-1]};
    assign rem_diff  = rem_sh - {1'b0, count_reg};
    assign rem_ge    = (rem_sh >= {1'b0, count_reg});
    assign q_low     = q_reg[OW-1:0];
    assign cnt_ext   = CNTX_W'(count_reg);

    assign status.seg_end   = seg_end_reg;
    assign status.seg_ok    = (sig_sum_reg != '0) && (noise_sum_reg != '0)
                              && (count_reg < COUNT_W'(MAX_SEGMENTS));
    assign status.last      = last_reg;
    assign status.norm_done = x_reg[NOISE_W-1];
    assign status.sq_done   = (round_reg == ssnr_pkg::LAST_ROUND);
    assign status.div_done  = (div_cnt_reg == DIVC_W'(TOTAL_W - 1));
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_mean  = $signed(out_mean_reg);
    assign out_count = out_count_reg;

    // configuration and control-like state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_len_reg   <= ssnr_pkg::SEG_LEN_RESET;
            out_valid_reg <= 1'b0;
            sig_sum_reg   <= '0;
            noise_sum_reg <= '0;
            pos_reg       <= '0;
            total_reg     <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                seg_len_reg <= cfg_segment_length;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.acc)
            begin
                sig_sum_reg   <= sig_sum_reg + SIG_W'(sig_sq_reg);
                noise_sum_reg <= noise_sum_reg + NOISE_W'(noise_sq_reg);
                if (!seg_end)
                begin
                    pos_reg <= pos_plus[POS_W-1:0];
                end
            end
            if (cmd.seg_clear || cmd.out_load)
            begin
                sig_sum_reg   <= '0;
                noise_sum_reg <= '0;
                pos_reg       <= '0;
            end
            if (cmd.add)
            begin
                total_reg <= total_reg + TOTAL_W'($signed(db_val));
                count_reg <= count_reg + COUNT_W'(1);
            end
            if (cmd.out_load)
            begin
                total_reg <= '0;
                count_reg <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            orig_reg <= original_sample;
            degr_reg <= degraded_sample;
            last_reg <= last;
        end
        if (cmd.mul)
        begin
            sig_sq_reg   <= sig_prod[30:0];
            noise_sq_reg <= noise_prod[31:0];
        end
        if (cmd.acc)
        begin
            seg_end_reg <= seg_end;
        end
        if (cmd.log_load_sig || cmd.log_load_noise)
        begin
            x_reg     <= cmd.log_load_sig ? NOISE_W'(sig_sum_reg) : noise_sum_reg;
            e_reg     <= E_W'(NOISE_W - 1);
            frac_reg  <= '0;
            round_reg <= '0;
        end
        if (cmd.log_load_noise)
        begin
            log_sig_reg <= {e_reg, frac_reg};
        end
        if (cmd.norm)
        begin
            // normalize: coarse steps first, then one bit
            if (x_reg[NOISE_W-1])
            begin
                m_reg <= x_reg[NOISE_W-1 -: MW];
            end
            else if (x_reg[NOISE_W-1 -: 16] == '0)
            begin
                x_reg <= x_reg << 16;
                e_reg <= e_reg - E_W'(16);
            end
            else if (x_reg[NOISE_W-1 -: 4] == '0)
            begin
                x_reg <= x_reg << 4;
                e_reg <= e_reg - E_W'(4);
            end
            else
            begin
                x_reg <= x_reg << 1;
                e_reg <= e_reg - E_W'(1);
            end
        end
        if (cmd.square)
        begin
            round_reg <= round_reg + 4'd1;
            frac_reg  <= {frac_reg[FW-2:0], m_p[MW]};
            m_reg     <= m_p[MW] ? m_p[MW:1] : m_p[MW-1:0];
        end
        if (cmd.db_mul)
        begin
            db_prod_reg <= PROD_W'(d_mag) * PROD_W'(ssnr_pkg::DB_FACTOR);
            db_neg_reg  <= d_log[LOG_W];
        end
        if (cmd.div_start)
        begin
            q_reg        <= total_mag + TOTAL_W'(count_reg >> 1);
            rem_reg      <= '0;
            div_cnt_reg  <= '0;
            mean_neg_reg <= total_reg[TOTAL_W-1];
        end
        if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + DIVC_W'(1);
            rem_reg     <= rem_ge ? rem_diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
            q_reg       <= {q_reg[TOTAL_W-2:0], rem_ge};
        end
        if (cmd.out_load)
        begin
            if (count_reg == '0)
            begin
                out_mean_reg <= '0;
            end
            else
            begin
                out_mean_reg <= mean_neg_reg ? (~q_low + OW'(1)) : q_low;
            end
            out_count_reg <= cnt_ext[ssnr_pkg::COUNT_OUT_W-1:0];
        end
    end

endmodule
`default_nettype wire

>>> design/segmental_snr_meter.sv
// Top level of the segmental SNR meter: controller, datapath and channel hookup.
//
//   channel   dir   payload                                   request taken when
//   samples   in    original_sample, degraded_sample, last    valid && ready
//   result    out   mean_snr_db, counted_segments             valid && ready
//   cfg       in    segment_length                            valid && ready
//
// A pair that does not end a segment passes the load, multiply, accumulate and
// check states. A pair that closes a counted segment runs two log2 passes
// through the one shared squaring unit (normalize, then 16 rounds each), a
// noise load state and dB scaling. A last pair adds the restoring divider over
// COUNT_W+15 quotient bits (32 at default), a setup state after a counted
// segment, and the output load. Reset clears all running state and sets
// segment_length to 160. A stalled result waits in the output register; the next
// result holds in the controller until it drains, and input stalls meanwhile.
`default_nettype none
module segmental_snr_meter #(
    parameter int MAX_SEGMENT_LENGTH = 4096,
    parameter int MAX_SEGMENTS       = 65536
) (
    input wire logic  clk,
    input wire logic  rst_n,
    ssnr_in_if.sink   samples,
    ssnr_out_if.source result,
    ssnr_cfg_if.sink  cfg
);

    ssnr_pkg::cmd_t    cmd;
    ssnr_pkg::status_t status;
    logic              in_ready;

    assign samples.ready = in_ready;

    ssnr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ssnr_datapath #(
        .MAX_SEGMENT_LENGTH (MAX_SEGMENT_LENGTH),
        .MAX_SEGMENTS       (MAX_SEGMENTS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .original_sample    (samples.original_sample),
        .degraded_sample    (samples.degraded_sample),
        .last               (samples.last),
        .cfg_valid          (cfg.valid),
        .cfg_ready          (cfg.ready),
        .cfg_segment_length (cfg.segment_length),
        .out_valid          (result.valid),
        .out_ready          (result.ready),
        .out_mean           (result.mean_snr_db),
        .out_count          (result.counted_segments)
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready |=> !samples.ready)
        else $error("sample request taken while previous one in work");

    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ($signed(result.mean_snr_db) >= -15'sd2560
                          && $signed(result.mean_snr_db) <= 15'sd12800))
        else $error("mean out of clamp range");

    a_empty_mean: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.counted_segments == 17'd0) |-> (result.mean_snr_db == 15'sd0))
        else $error("nonzero mean with no counted segment");
`endif

endmodule
`default_nettype wire
